// ===== rtl/core/fast_sigmoid_activation_unit_assert.svh =====
// Assertion macros for the RTL; sampled on clock, off during reset.
`ifndef FAST_SIGMOID_ACTIVATION_UNIT_ASSERT_SVH
`define FAST_SIGMOID_ACTIVATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSAU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsau: same-cycle implication failed");

// Next-cycle implication.
`define FSAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsau: next-cycle implication failed");

`endif

// ===== rtl/core/fsau_pkg.sv =====
`default_nettype none

package fsau_pkg;

   // Field widths
   localparam int VALUE_W  = 24;
   localparam int RESULT_W = 16;

   // Divider geometry: 16 quotient bits, one per stage
   localparam int QUO_W      = 16;
   localparam int DIV_STAGES = QUO_W;
   localparam int REM_W      = 48;
   localparam int DS_W       = REM_W + QUO_W - 1;

   // Mode codes
   localparam logic FUNC_SIGMOID = 1'b0;
   localparam logic FUNC_DERIV   = 1'b1;

   // Fixed-point one in Q.16
   localparam logic [VALUE_W-1:0] FRAC_ONE = VALUE_W'(32'h0001_0000);

   // Word carried through the divider stages
   typedef struct packed {
      logic             func;
      logic             neg;
      logic [REM_W-1:0] rem;
      logic [DS_W-1:0]  ds;
      logic [QUO_W-1:0] quo;
   } div_word_type;

endpackage

`default_nettype wire

// ===== rtl/core/fsau_req_if.sv =====
`default_nettype none

interface fsau_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic signed [fsau_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsau_rsp_if.sv =====
`default_nettype none

interface fsau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsau_pkg::RESULT_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsau_div_stage.sv =====
`default_nettype none

// One restoring-division step: compare, conditional subtract, one quotient bit.
module fsau_div_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  fsau_pkg::div_word_type       in_word,
   output logic                         up_ready,
   output logic                         out_valid,
   output fsau_pkg::div_word_type       out_word,
   input  wire                          down_ready
);

   logic                   valid_ff;
   fsau_pkg::div_word_type word_ff;
   fsau_pkg::div_word_type word_in;
   logic                   take_ge;

   // Stage takes a word when empty or when its word moves on
   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Trial subtract against the shifted divisor
   always_comb begin
      take_ge       = {{(fsau_pkg::QUO_W-1){1'b0}}, in_word.rem} >= in_word.ds;
      word_in       = in_word;
      word_in.rem   = take_ge ? (in_word.rem - in_word.ds[fsau_pkg::REM_W-1:0])
                              : in_word.rem;
      word_in.ds    = in_word.ds >> 1;
      word_in.quo   = {in_word.quo[fsau_pkg::QUO_W-2:0], take_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fast_sigmoid_activation_unit.sv =====
// Fast sigmoid unit: takes a signed Q7.16 word and a mode bit, returns an unsigned
// Q0.16 word: softsign sigmoid (x/(1+|x|)+1)/2 in sigmoid mode, its derivative
// 1/(2(|x|+1)^2) in derivative mode. Fully pipelined: one word per cycle unless the output is
// held, through 19 register stages (magnitude stage, squaring stage, 16 one-bit division
// stages, output stage). The 16-stage restoring divider sets the latency. Stages advance
// independently, so bubbles close up under back-pressure.
`default_nettype none

`include "fast_sigmoid_activation_unit_assert.svh"

module fast_sigmoid_activation_unit (
   input  wire        clock,
   input  wire        reset,
   fsau_req_if.sink   req,
   fsau_rsp_if.source rsp
);

   // Stage 0: magnitude and denominator
   logic                          s0_valid_ff;
   logic                          s0_ready;
   logic                          s0_func_ff;
   logic                          s0_neg_ff;
   logic [fsau_pkg::VALUE_W-1:0]  s0_mag_ff;
   logic [fsau_pkg::VALUE_W-1:0]  s0_den_ff;
   logic [fsau_pkg::VALUE_W-1:0]  s0_mag_in;

   // Stage 1: square and operand select
   logic                          s1_valid_ff;
   logic                          s1_ready;
   fsau_pkg::div_word_type        s1_word_ff;
   fsau_pkg::div_word_type        s1_word_in;
   logic [2*fsau_pkg::VALUE_W-1:0] s1_sq;

   // Divider chain
   logic                          div_valid [0:fsau_pkg::DIV_STAGES];
   logic                          div_ready [0:fsau_pkg::DIV_STAGES];
   fsau_pkg::div_word_type        div_word  [0:fsau_pkg::DIV_STAGES];

   // Output stage
   logic                          out_valid_ff;
   logic                          out_ready;
   logic                          out_func_ff;
   logic                          out_neg_ff;
   logic [fsau_pkg::RESULT_W-1:0] out_result_ff;
   logic [fsau_pkg::RESULT_W-1:0] out_result_in;
   logic [fsau_pkg::QUO_W:0]      out_diff;
   fsau_pkg::div_word_type        last_word;
   logic                          out_is_deriv;
   logic                          out_is_sig;

   // ---- stage 0 ----
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req.ready = s0_ready;
   assign s0_mag_in = req.value[fsau_pkg::VALUE_W-1] ? (~req.value + 1'b1) : req.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req.valid) begin
         s0_func_ff <= req.func;
         s0_neg_ff  <= req.value[fsau_pkg::VALUE_W-1];
         s0_mag_ff  <= s0_mag_in;
         s0_den_ff  <= s0_mag_in + fsau_pkg::FRAC_ONE;
      end
   end

   // ---- stage 1: numerator and divisor, divisor aligned to top quotient bit ----
   assign s1_ready = !s1_valid_ff || div_ready[0];
   assign s1_sq    = (2*fsau_pkg::VALUE_W)'(s0_den_ff) * (2*fsau_pkg::VALUE_W)'(s0_den_ff);

   always_comb begin
      s1_word_in.func = s0_func_ff;
      s1_word_in.neg  = s0_neg_ff;
      s1_word_in.quo  = '0;
      if (s0_func_ff == fsau_pkg::FUNC_DERIV) begin
         s1_word_in.rem = {1'b1, {(fsau_pkg::REM_W-1){1'b0}}};
         s1_word_in.ds  = {s1_sq[fsau_pkg::REM_W-1:0], {(fsau_pkg::QUO_W-1){1'b0}}};
      end else begin
         s1_word_in.rem = {{(fsau_pkg::REM_W-fsau_pkg::VALUE_W-fsau_pkg::QUO_W){1'b0}},
                           s0_mag_ff, {fsau_pkg::QUO_W{1'b0}}};
         s1_word_in.ds  = {{(fsau_pkg::REM_W-fsau_pkg::VALUE_W){1'b0}},
                           s0_den_ff, {(fsau_pkg::QUO_W-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s0_valid_ff) begin
         s1_word_ff <= s1_word_in;
      end
   end

   assign div_valid[0] = s1_valid_ff;
   assign div_word[0]  = s1_word_ff;

   // ---- divider: one quotient bit per stage ----
   for (genvar k = 0; k < fsau_pkg::DIV_STAGES; k++) begin : g_div
      fsau_div_stage u_div_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (div_valid[k]),
         .in_word    (div_word[k]),
         .up_ready   (div_ready[k]),
         .out_valid  (div_valid[k+1]),
         .out_word   (div_word[k+1]),
         .down_ready (div_ready[k+1])
      );
   end

   assign div_ready[fsau_pkg::DIV_STAGES] = out_ready;
   assign last_word = div_word[fsau_pkg::DIV_STAGES];

   // ---- output stage: fold the quotient into the final fraction ----
   assign out_ready = !out_valid_ff || rsp.ready;
   assign out_diff  = {1'b1, {fsau_pkg::QUO_W{1'b0}}} - {1'b0, last_word.quo};

   always_comb begin
      if (last_word.func == fsau_pkg::FUNC_DERIV) begin
         out_result_in = last_word.quo;
      end else if (last_word.neg) begin
         out_result_in = out_diff[fsau_pkg::QUO_W:1];
      end else begin
         out_result_in = {1'b1, last_word.quo[fsau_pkg::QUO_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div_valid[fsau_pkg::DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[fsau_pkg::DIV_STAGES]) begin
         out_result_ff <= out_result_in;
         out_func_ff   <= last_word.func;
         out_neg_ff    <= last_word.neg;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.result = out_result_ff;

   // ---- checks ----
   assign out_is_deriv = out_valid_ff && (out_func_ff == fsau_pkg::FUNC_DERIV);
   assign out_is_sig   = out_valid_ff && (out_func_ff == fsau_pkg::FUNC_SIGMOID);

   `FSAU_ASSERT_NEXT(a_accept_fills_s0, req.valid && req.ready, s0_valid_ff)
   `FSAU_ASSERT_IMP(a_deriv_bound, out_is_deriv, out_result_ff <= 16'h8000)
   `FSAU_ASSERT_IMP(a_sig_pos_half, out_is_sig && !out_neg_ff, out_result_ff >= 16'h8000)
   `FSAU_ASSERT_IMP(a_sig_neg_half, out_is_sig && out_neg_ff, out_result_ff <= 16'h8000)

endmodule

`default_nettype wire

// ===== tb/tb_fast_sigmoid_activation_unit.sv =====
`default_nettype none

module tb_fast_sigmoid_activation_unit;

   localparam int          RANDOM_WORDS = 950;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          HOLD_CYCLES  = 150;
   localparam int          HOLD_AFTER   = 400;
   localparam longint unsigned ONE_Q16  = 64'd65536;

   typedef struct packed {
      logic                          mode;
      logic [fsau_pkg::VALUE_W-1:0]  x;
      logic                          known;
      logic [fsau_pkg::RESULT_W-1:0] want;
   } probe_row_type;

   // Directed words: typed results only where they are obvious
   probe_row_type probe_rows [0:19] = '{
      '{fsau_pkg::FUNC_SIGMOID, 24'h000000, 1'b1, 16'd32768},
      '{fsau_pkg::FUNC_DERIV,   24'h000000, 1'b1, 16'd32768},
      '{fsau_pkg::FUNC_SIGMOID, 24'h010000, 1'b1, 16'd49152},
      '{fsau_pkg::FUNC_DERIV,   24'h010000, 1'b1, 16'd8192},
      '{fsau_pkg::FUNC_SIGMOID, 24'hFF0000, 1'b1, 16'd16384},
      '{fsau_pkg::FUNC_DERIV,   24'hFF0000, 1'b1, 16'd8192},
      '{fsau_pkg::FUNC_SIGMOID, 24'h800000, 1'b1, 16'd254},
      '{fsau_pkg::FUNC_DERIV,   24'h800000, 1'b1, 16'd1},
      '{fsau_pkg::FUNC_SIGMOID, 24'h7FFFFF, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'h7FFFFF, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_SIGMOID, 24'h800001, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'h800001, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_SIGMOID, 24'h000001, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'h000001, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_SIGMOID, 24'hFFFFFF, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'hFFFFFF, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_SIGMOID, 24'h555555, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'hAAAAAA, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_SIGMOID, 24'hAAAAAA, 1'b0, 16'd0},
      '{fsau_pkg::FUNC_DERIV,   24'h555555, 1'b0, 16'd0}
   };

   logic clock = 1'b0;
   logic reset;

   fsau_req_if req_ch ();
   fsau_rsp_if rsp_ch ();

   fast_sigmoid_activation_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   logic [fsau_pkg::RESULT_W-1:0] pending_activations [$];
   logic [fsau_pkg::RESULT_W-1:0] oldest_activation;
   int errors          = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int sigmoid_words   = 0;
   int deriv_words     = 0;
   int negative_words  = 0;
   int burst_left      = 0;

   // Softsign sigmoid or its derivative, exact integer form
   function automatic logic [fsau_pkg::RESULT_W-1:0] fast_sigmoid_of(
         input logic mode, input logic [fsau_pkg::VALUE_W-1:0] x);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned quo;
      logic            neg;
      neg = x[fsau_pkg::VALUE_W-1];
      mag = 64'(x);
      if (neg)
         mag = (64'd1 << fsau_pkg::VALUE_W) - mag;
      den = mag + ONE_Q16;
      if (mode == fsau_pkg::FUNC_DERIV) begin
         quo = (64'd1 << 47) / (den * den);
      end else begin
         quo = (mag << 16) / den;
         quo = neg ? (ONE_Q16 - quo) >> 1 : (ONE_Q16 + quo) >> 1;
      end
      return quo[fsau_pkg::RESULT_W-1:0];
   endfunction

   // Random value drawn from a few classes that stress the divider
   function automatic logic [fsau_pkg::VALUE_W-1:0] pick_value();
      logic [fsau_pkg::VALUE_W-1:0] x;
      case ($urandom_range(0, 5))
         0, 1: x = fsau_pkg::VALUE_W'($urandom());
         2:    x = fsau_pkg::VALUE_W'($urandom_range(0, 1 << 18));
         3:    x = $urandom_range(0, 1)
                   ? 24'h800000 + fsau_pkg::VALUE_W'($urandom_range(0, 15))
                   : 24'h7FFFFF - fsau_pkg::VALUE_W'($urandom_range(0, 15));
         4:    x = (24'd1 << $urandom_range(0, 22))
                   + fsau_pkg::VALUE_W'($urandom_range(0, 2)) - 24'd1;
         default: x = fsau_pkg::VALUE_W'($urandom_range(0, 63));
      endcase
      if ($urandom_range(0, 1))
         x = -x;
      return x;
   endfunction

   // Offer one word in bursts with random gaps; record its result once accepted
   task automatic drive_word(input logic mode, input logic [fsau_pkg::VALUE_W-1:0] x,
                             input logic known,
                             input logic [fsau_pkg::RESULT_W-1:0] want);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= mode;
      req_ch.value <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_activations.push_back(known ? want : fast_sigmoid_of(mode, x));
      if (mode == fsau_pkg::FUNC_DERIV) deriv_words++;
      else sigmoid_words++;
      if (x[fsau_pkg::VALUE_W-1]) negative_words++;
      burst_left--;
   endtask

   // Result side: stall pattern changes now and then, one long hold-off
   initial begin
      int  hold_left;
      int  style;
      bit  hold_done;
      hold_left = 0;
      style     = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count % 200 == 0)
            style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= (cycle_count % 7) >= 2;
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_activations.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0d",
                     $time, rsp_ch.result);
            errors++;
         end else begin
            oldest_activation = pending_activations.pop_front();
            if (rsp_ch.result !== oldest_activation) begin
               $display("%0t: result mismatch, expected %0d, actual %0d",
                        $time, oldest_activation, rsp_ch.result);
               errors++;
            end
            results_checked++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_activations.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Reset, directed words, random words, drain
   initial begin
      int row;
      int n;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func  = fsau_pkg::FUNC_SIGMOID;
      req_ch.value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < 20; row++)
         drive_word(probe_rows[row].mode, probe_rows[row].x,
                    probe_rows[row].known, probe_rows[row].want);

      for (n = 0; n < RANDOM_WORDS; n++)
         drive_word($urandom_range(0, 1) ? fsau_pkg::FUNC_DERIV : fsau_pkg::FUNC_SIGMOID,
                    pick_value(), 1'b0, '0);

      req_ch.valid <= 1'b0;
      while (pending_activations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sigmoid and %0d derivative words (%0d negative inputs),",
               sigmoid_words, deriv_words, negative_words);
      $display("checked %0d results with one long output hold-off; %0d errors",
               results_checked, errors);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
